// ----- rtl/srt_pkg.sv -----
// srt_pkg: shared constants, codes and types of the sorted record table
// depends on nothing; used by the interfaces, the cell, the controller and the top level
`default_nettype none

package srt_pkg;

    // table size and field widths
    localparam int DEPTH     = 16;
    localparam int KEY_W     = 20;
    localparam int SAL_W     = 24;
    localparam int SUM_W     = 28;
    localparam int REQ_W     = 2;
    localparam int STAT_W    = 2;
    localparam int CNT_OUT_W = 5;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int WAIT_W    = $clog2(DEPTH);

    // request codes (the unused code is treated as a search)
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

    // one stored record
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [SAL_W-1:0] salary;
    } t_entry;

    // broadcast command to all cells
    typedef struct packed {
        logic             ins;
        logic             del;
        logic [KEY_W-1:0] key;
        logic [SAL_W-1:0] salary;
    } t_cmd;

    // compare flags a cell hands to its right neighbor and to the top level
    typedef struct packed {
        logic gt;
        logic match;
        logic first;
    } t_flags;

    // running salary min/max rippling down the chain
    typedef struct packed {
        logic             any;
        logic [SAL_W-1:0] min;
        logic [SAL_W-1:0] max;
    } t_agg;

endpackage

`default_nettype wire

// ----- rtl/srt_req_if.sv -----
// srt_req_if: request channel of the sorted record table (valid/ready + payload)
// depends on srt_pkg for field widths
`default_nettype none

interface srt_req_if;
    logic                         valid;
    logic                         ready;
    logic [srt_pkg::REQ_W-1:0]    req_type;
    logic [srt_pkg::KEY_W-1:0]    key;
    logic [srt_pkg::SAL_W-1:0]    salary;

    modport source (output valid, req_type, key, salary, input ready);
    modport sink   (input valid, req_type, key, salary, output ready);
endinterface

`default_nettype wire

// ----- rtl/srt_rsp_if.sv -----
// srt_rsp_if: response channel of the sorted record table (valid/ready + payload)
// depends on srt_pkg for field widths
`default_nettype none

interface srt_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [srt_pkg::STAT_W-1:0]       status;
    logic [srt_pkg::CNT_OUT_W-1:0]    count;
    logic [srt_pkg::SUM_W-1:0]        salary_sum;
    logic [srt_pkg::SAL_W-1:0]        salary_min;
    logic [srt_pkg::SAL_W-1:0]        salary_max;

    modport source (output valid, status, count, salary_sum, salary_min, salary_max,
                    input ready);
    modport sink   (input valid, status, count, salary_sum, salary_min, salary_max,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/srt_cell.sv -----
// srt_cell: one slot of the sorted chain; holds a record, shifts right on insert,
// left on delete, and passes the salary min/max aggregate on to its neighbor
// depends on srt_pkg
`default_nettype none

module srt_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire srt_pkg::t_cmd   i_cmd,
    input  wire srt_pkg::t_entry i_prev_entry,
    input  wire srt_pkg::t_flags i_prev_flags,
    input  wire srt_pkg::t_entry i_next_entry,
    input  wire srt_pkg::t_agg   i_prev_agg,
    output srt_pkg::t_entry      o_entry,
    output srt_pkg::t_flags      o_flags,
    output srt_pkg::t_agg        o_agg
);

    srt_pkg::t_entry r_entry;
    srt_pkg::t_entry n_entry;
    srt_pkg::t_agg   r_agg;
    srt_pkg::t_agg   n_agg;
    logic            w_ge;

    // key compares against the broadcast key
    always_comb begin
        o_flags.gt    = !r_entry.valid || (r_entry.key > i_cmd.key);
        o_flags.match = r_entry.valid && (r_entry.key == i_cmd.key);
        o_flags.first = o_flags.match && !i_prev_flags.match;
        w_ge          = r_entry.valid && (r_entry.key >= i_cmd.key);
    end

    // next slot contents: shift right on insert, pull from the right on delete
    always_comb begin
        n_entry = r_entry;
        if (i_cmd.ins) begin
            if (i_prev_flags.gt) begin
                n_entry = i_prev_entry;
            end else if (o_flags.gt) begin
                n_entry = '{valid: 1'b1, key: i_cmd.key, salary: i_cmd.salary};
            end
        end else if (i_cmd.del && w_ge) begin
            n_entry = i_next_entry;
        end
    end

    // slot register: only the valid flag is reset, the payload just follows
    always_ff @(posedge i_clk) begin
        r_entry.key    <= n_entry.key;
        r_entry.salary <= n_entry.salary;
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
        end
    end

    // fold this slot into the aggregate coming from the left
    always_comb begin
        n_agg = i_prev_agg;
        if (r_entry.valid) begin
            n_agg.any = 1'b1;
            if (!i_prev_agg.any) begin
                n_agg.min = r_entry.salary;
                n_agg.max = r_entry.salary;
            end else begin
                n_agg.min = (r_entry.salary < i_prev_agg.min) ? r_entry.salary
                                                              : i_prev_agg.min;
                n_agg.max = (r_entry.salary > i_prev_agg.max) ? r_entry.salary
                                                              : i_prev_agg.max;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_agg <= n_agg;
    end

    assign o_entry = r_entry;
    assign o_agg   = r_agg;

endmodule

`default_nettype wire

// ----- rtl/srt_ctrl.sv -----
// srt_ctrl: request handshake, record count, salary sum, sweep wait and result register
// depends on srt_pkg, srt_req_if and srt_rsp_if
`default_nettype none

module srt_ctrl (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    srt_req_if.sink                         i_req,
    srt_rsp_if.source                       o_rsp,
    input  wire logic                       i_found,
    input  wire logic                       i_full,
    input  wire logic [srt_pkg::SAL_W-1:0]  i_del_salary,
    input  wire srt_pkg::t_agg              i_last_agg
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SWEEP = 3'b010,
        S_FLUSH = 3'b100
    } t_state;

    t_state                           r_state;
    t_state                           n_state;
    logic [srt_pkg::WAIT_W-1:0]       r_wait;
    logic [srt_pkg::CNT_W-1:0]        r_count;
    logic [srt_pkg::SUM_W-1:0]        r_sum;
    logic [srt_pkg::STAT_W-1:0]       r_status;
    logic                             r_out_valid;
    logic [srt_pkg::STAT_W-1:0]       r_out_status;
    logic [srt_pkg::CNT_OUT_W-1:0]    r_out_count;
    logic [srt_pkg::SUM_W-1:0]        r_out_sum;
    logic [srt_pkg::SAL_W-1:0]        r_out_min;
    logic [srt_pkg::SAL_W-1:0]        r_out_max;
    logic                             w_accept;
    logic                             w_load;
    logic                             w_is_ins;
    logic                             w_is_del;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_is_ins    = (i_req.req_type == srt_pkg::REQ_INSERT);
    assign w_is_del    = (i_req.req_type == srt_pkg::REQ_DELETE);
    assign w_load      = (r_state == S_FLUSH) && (!r_out_valid || o_rsp.ready);

    // state sequencing
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_SWEEP;
            end
            S_SWEEP: begin
                if (r_wait == srt_pkg::WAIT_W'(srt_pkg::DEPTH - 1)) n_state = S_FLUSH;
            end
            S_FLUSH: begin
                if (w_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sweep wait counter: lets the min/max aggregate ripple down the chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait <= '0;
        end else if (r_state == S_SWEEP) begin
            r_wait <= r_wait + 1'b1;
        end else begin
            r_wait <= '0;
        end
    end

    // count, sum and status bookkeeping at request acceptance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_sum    <= '0;
            r_status <= srt_pkg::STAT_OK;
        end else if (w_accept) begin
            if (w_is_ins) begin
                if (i_full) begin
                    r_status <= srt_pkg::STAT_FULL;
                end else begin
                    r_status <= srt_pkg::STAT_OK;
                    r_count  <= r_count + 1'b1;
                    r_sum    <= r_sum + srt_pkg::SUM_W'(i_req.salary);
                end
            end else if (w_is_del) begin
                if (i_found) begin
                    r_status <= srt_pkg::STAT_OK;
                    r_count  <= r_count - 1'b1;
                    r_sum    <= r_sum - srt_pkg::SUM_W'(i_del_salary);
                end else begin
                    r_status <= srt_pkg::STAT_MISS;
                end
            end else begin
                r_status <= i_found ? srt_pkg::STAT_OK : srt_pkg::STAT_MISS;
            end
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_status <= r_status;
            r_out_count  <= srt_pkg::CNT_OUT_W'(r_count);
            r_out_sum    <= r_sum;
            r_out_min    <= i_last_agg.min;
            r_out_max    <= i_last_agg.max;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.count      = r_out_count;
    assign o_rsp.salary_sum = r_out_sum;
    assign o_rsp.salary_min = r_out_min;
    assign o_rsp.salary_max = r_out_max;

    // record count stays within the table size
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= srt_pkg::CNT_W'(srt_pkg::DEPTH))
        else $error("record count beyond table size");

    // an accepted request always starts a fresh sweep
    a_accept_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_SWEEP) && (r_wait == '0))
        else $error("accepted request did not start a sweep");

    // an insert into a full table leaves count and sum alone
    a_full_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_is_ins && i_full) |=>
            (r_count == $past(r_count)) && (r_sum == $past(r_sum))
            && (r_status == srt_pkg::STAT_FULL))
        else $error("rejected insert changed the table");

    // a result load never overwrites an untaken result
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH) && r_out_valid && !o_rsp.ready |=> (r_state == S_FLUSH))
        else $error("result register overwritten");

endmodule

`default_nettype wire

// ----- rtl/sorted_record_table_top.sv -----
// sorted_record_table_top: a record table kept in ascending key order as a chain
// of cells; one request is accepted in the idle state, the chain updates at acceptance
// and the salary min/max aggregate then ripples through every cell. The result is
// registered once the sweep wait has let the aggregate ripple through the chain and
// any earlier result has been taken; the next request is taken only after that load.
// Inserts after equal keys, deletes the oldest equal key, and answers 0 for min/max
// on an empty table.
// depends on srt_pkg, srt_req_if, srt_rsp_if, srt_cell and srt_ctrl
`default_nettype none

module sorted_record_table_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    srt_req_if.sink   i_req,
    srt_rsp_if.source o_rsp
);

    srt_pkg::t_entry                w_entry [srt_pkg::DEPTH];
    srt_pkg::t_flags                w_flags [srt_pkg::DEPTH];
    srt_pkg::t_agg                  w_agg   [srt_pkg::DEPTH];
    srt_pkg::t_cmd                  w_cmd;
    logic                           w_accept;
    logic                           w_found;
    logic                           w_full;
    logic [srt_pkg::SAL_W-1:0]      w_del_salary;

    assign w_accept = i_req.valid && i_req.ready;
    assign w_full   = w_entry[srt_pkg::DEPTH-1].valid;

    // search result and salary of the first matching record
    always_comb begin
        w_found      = 1'b0;
        w_del_salary = '0;
        for (int i = 0; i < srt_pkg::DEPTH; i++) begin
            w_found      = w_found | w_flags[i].match;
            w_del_salary = w_del_salary | ({srt_pkg::SAL_W{w_flags[i].first}}
                                           & w_entry[i].salary);
        end
    end

    // command broadcast to the chain
    always_comb begin
        w_cmd.ins    = w_accept && (i_req.req_type == srt_pkg::REQ_INSERT) && !w_full;
        w_cmd.del    = w_accept && (i_req.req_type == srt_pkg::REQ_DELETE) && w_found;
        w_cmd.key    = i_req.key;
        w_cmd.salary = i_req.salary;
    end

    // the chain of cells
    for (genvar g = 0; g < srt_pkg::DEPTH; g++) begin : g_cell
        srt_pkg::t_entry w_prev_entry;
        srt_pkg::t_flags w_prev_flags;
        srt_pkg::t_entry w_next_entry;
        srt_pkg::t_agg   w_prev_agg;

        if (g == 0) begin : g_head
            assign w_prev_entry = '0;
            assign w_prev_flags = '0;
            assign w_prev_agg   = '0;
        end else begin : g_body
            assign w_prev_entry = w_entry[g-1];
            assign w_prev_flags = w_flags[g-1];
            assign w_prev_agg   = w_agg[g-1];
        end

        if (g == srt_pkg::DEPTH - 1) begin : g_tail
            assign w_next_entry = '0;
        end else begin : g_inner
            assign w_next_entry = w_entry[g+1];
        end

        srt_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_prev_entry (w_prev_entry),
            .i_prev_flags (w_prev_flags),
            .i_next_entry (w_next_entry),
            .i_prev_agg   (w_prev_agg),
            .o_entry      (w_entry[g]),
            .o_flags      (w_flags[g]),
            .o_agg        (w_agg[g])
        );
    end

    srt_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .o_rsp        (o_rsp),
        .i_found      (w_found),
        .i_full       (w_full),
        .i_del_salary (w_del_salary),
        .i_last_agg   (w_agg[srt_pkg::DEPTH-1])
    );

endmodule

`default_nettype wire

// ----- tb/sv/tb_sorted_record_table_top.sv -----
// tb_sorted_record_table_top: self-checking bench for the sorted record table, with
// directed and random request traffic against an in-bench table predictor
// depends on srt_pkg, srt_req_if, srt_rsp_if and sorted_record_table_top
`timescale 1ns / 100ps

module tb_sorted_record_table_top;

    // the fourth request code has no name in the package and acts as a search
    localparam logic [srt_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = srt_pkg::DEPTH + 4;

    typedef enum int {BIAS_FILL, BIAS_MIXED, BIAS_DRAIN} t_bias;

    // summary returned for one transaction
    typedef struct packed {
        logic [srt_pkg::STAT_W-1:0]    status;
        logic [srt_pkg::CNT_OUT_W-1:0] count;
        logic [srt_pkg::SUM_W-1:0]     salary_sum;
        logic [srt_pkg::SAL_W-1:0]     salary_min;
        logic [srt_pkg::SAL_W-1:0]     salary_max;
    } t_table_summary;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    srt_req_if req_ch();
    srt_rsp_if rsp_ch();

    sorted_record_table_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always #1 i_clk = ~i_clk;

    // predicted table contents, sorted prefix of held records
    logic [srt_pkg::KEY_W-1:0] tbl_key [srt_pkg::DEPTH];
    logic [srt_pkg::SAL_W-1:0] tbl_sal [srt_pkg::DEPTH];
    int                        held    = 0;
    logic [srt_pkg::SUM_W-1:0] tbl_sum = '0;

    t_table_summary expected_results [$];
    int mismatch_count = 0;
    int burst_left     = 0;
    int idle_cycles    = 0;

    // apply one request to the predicted table and return its summary
    function automatic t_table_summary apply_to_table(
        input logic [srt_pkg::REQ_W-1:0] rt,
        input logic [srt_pkg::KEY_W-1:0] k,
        input logic [srt_pkg::SAL_W-1:0] s);
        t_table_summary r;
        int pos;
        int i;
        r.status = srt_pkg::STAT_OK;
        if (rt == srt_pkg::REQ_INSERT) begin
            if (held >= srt_pkg::DEPTH) begin
                r.status = srt_pkg::STAT_FULL;
            end else begin
                // new record goes after every equal key
                pos = 0;
                while (pos < held && tbl_key[pos] <= k) pos++;
                for (i = held; i > pos; i--) begin
                    tbl_key[i] = tbl_key[i-1];
                    tbl_sal[i] = tbl_sal[i-1];
                end
                tbl_key[pos] = k;
                tbl_sal[pos] = s;
                tbl_sum = tbl_sum + srt_pkg::SUM_W'(s);
                held++;
            end
        end else if (rt == srt_pkg::REQ_DELETE) begin
            // oldest matching record goes, the head slot included
            pos = 0;
            while (pos < held && tbl_key[pos] != k) pos++;
            if (pos >= held) begin
                r.status = srt_pkg::STAT_MISS;
            end else begin
                tbl_sum = tbl_sum - srt_pkg::SUM_W'(tbl_sal[pos]);
                for (i = pos; i + 1 < held; i++) begin
                    tbl_key[i] = tbl_key[i+1];
                    tbl_sal[i] = tbl_sal[i+1];
                end
                held--;
            end
        end else begin
            r.status = srt_pkg::STAT_MISS;
            for (i = 0; i < held; i++) begin
                if (tbl_key[i] == k) r.status = srt_pkg::STAT_OK;
            end
        end
        r.count      = srt_pkg::CNT_OUT_W'(held);
        r.salary_sum = tbl_sum;
        r.salary_min = '0;
        r.salary_max = '0;
        if (held > 0) begin
            r.salary_min = tbl_sal[0];
            r.salary_max = tbl_sal[0];
            for (i = 1; i < held; i++) begin
                if (tbl_sal[i] < r.salary_min) r.salary_min = tbl_sal[i];
                if (tbl_sal[i] > r.salary_max) r.salary_max = tbl_sal[i];
            end
        end
        return r;
    endfunction

    // send one request in bursts with random gaps, record its expected summary
    task automatic send_request(input logic [srt_pkg::REQ_W-1:0] rt,
                                input logic [srt_pkg::KEY_W-1:0] k,
                                input logic [srt_pkg::SAL_W-1:0] s);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) == 0) begin
                burst_left = $urandom_range(20, 60);
            end else begin
                burst_left = $urandom_range(1, 10);
                gap        = $urandom_range(1, 40);
            end
        end
        burst_left--;
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= rt;
        req_ch.key      <= k;
        req_ch.salary   <= s;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        expected_results.push_back(apply_to_table(rt, k, s));
    endtask

    // hold off the sender until every pending summary has come back
    task automatic wait_for_results();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    // requests on an empty table
    task automatic test_empty_table();
        send_request(srt_pkg::REQ_SEARCH, '0, '0);
        send_request(srt_pkg::REQ_DELETE, '1, '1);
    endtask

    // extreme keys and salaries, duplicate keys, head delete, unused code
    task automatic test_extremes_and_duplicates();
        send_request(srt_pkg::REQ_INSERT, '1, '1);
        send_request(srt_pkg::REQ_INSERT, '0, '0);
        send_request(srt_pkg::REQ_INSERT, 20'h12345, 24'd100);
        send_request(srt_pkg::REQ_INSERT, 20'h12345, 24'd200);
        send_request(srt_pkg::REQ_INSERT, 20'h12345, 24'd300);
        send_request(srt_pkg::REQ_DELETE, 20'h12345, '0);
        send_request(srt_pkg::REQ_DELETE, '0, '1);
        send_request(REQ_UNUSED, 20'h12345, '0);
    endtask

    // fill the table, then reject an insert and miss a delete
    task automatic test_fill_to_full();
        while (held < srt_pkg::DEPTH) begin
            send_request(srt_pkg::REQ_INSERT,
                         srt_pkg::KEY_W'($urandom()) & ~srt_pkg::KEY_W'(1),
                         srt_pkg::SAL_W'($urandom()));
        end
        send_request(srt_pkg::REQ_INSERT, 20'h00042, 24'h00abcd);
        send_request(srt_pkg::REQ_DELETE, 20'h0abcd, '0);
    endtask

    // phases of random traffic drawn mostly from small key pools
    task automatic test_random_churn();
        logic [srt_pkg::KEY_W-1:0] key_pool [8];
        logic [srt_pkg::KEY_W-1:0] k;
        logic [srt_pkg::SAL_W-1:0] s;
        logic [srt_pkg::REQ_W-1:0] rt;
        t_bias bias;
        int ins_pct;
        int del_pct;
        int n_items;
        int roll;
        for (int ph = 0; ph < 12; ph++) begin
            bias = t_bias'(ph % 3);
            case (bias)
                BIAS_FILL: begin
                    ins_pct = 75;
                    del_pct = 15;
                end
                BIAS_MIXED: begin
                    ins_pct = 45;
                    del_pct = 35;
                end
                default: begin
                    ins_pct = 20;
                    del_pct = 65;
                end
            endcase
            for (int j = 0; j < 8; j++) begin
                case ($urandom_range(0, 3))
                    0: key_pool[j] = srt_pkg::KEY_W'($urandom_range(0, 15));
                    1: key_pool[j] = '1 - srt_pkg::KEY_W'($urandom_range(0, 15));
                    default: key_pool[j] = srt_pkg::KEY_W'($urandom());
                endcase
            end
            n_items = $urandom_range(80, 110);
            for (int n = 0; n < n_items; n++) begin
                case ($urandom_range(0, 9))
                    0: s = '0;
                    1: s = '1;
                    default: s = srt_pkg::SAL_W'($urandom());
                endcase
                k    = key_pool[$urandom_range(0, 7)];
                roll = $urandom_range(0, 99);
                if ($urandom_range(0, 19) == 0) begin
                    // noise: any code, any key
                    rt = srt_pkg::REQ_W'($urandom());
                    k  = srt_pkg::KEY_W'($urandom());
                end else if (roll < ins_pct) begin
                    rt = srt_pkg::REQ_INSERT;
                end else begin
                    rt = (roll < ins_pct + del_pct) ? srt_pkg::REQ_DELETE
                         : (($urandom_range(0, 3) == 0) ? REQ_UNUSED : srt_pkg::REQ_SEARCH);
                    if (held > 0 && $urandom_range(0, 4) != 0) begin
                        k = tbl_key[$urandom_range(0, held - 1)];
                    end
                end
                send_request(rt, k, s);
            end
            if (ph % 4 == 3) wait_for_results();
        end
    endtask

    // response receiver with its own stall pattern and the result checker
    initial begin : result_checker
        t_table_summary exp_r;
        int stall_left;
        int cyc;
        rsp_ch.ready = 1'b0;
        stall_left   = 0;
        cyc          = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transaction with no request outstanding");
                    mismatch_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (rsp_ch.status !== exp_r.status) begin
                        $error("status expected %0d actual %0d", exp_r.status, rsp_ch.status);
                        mismatch_count++;
                    end
                    if (rsp_ch.count !== exp_r.count) begin
                        $error("count expected %0d actual %0d", exp_r.count, rsp_ch.count);
                        mismatch_count++;
                    end
                    if (rsp_ch.salary_sum !== exp_r.salary_sum) begin
                        $error("salary_sum expected %0d actual %0d", exp_r.salary_sum,
                               rsp_ch.salary_sum);
                        mismatch_count++;
                    end
                    if (rsp_ch.salary_min !== exp_r.salary_min) begin
                        $error("salary_min expected %0d actual %0d", exp_r.salary_min,
                               rsp_ch.salary_min);
                        mismatch_count++;
                    end
                    if (rsp_ch.salary_max !== exp_r.salary_max) begin
                        $error("salary_max expected %0d actual %0d", exp_r.salary_max,
                               rsp_ch.salary_max);
                        mismatch_count++;
                    end
                end
            end
            // stall pattern steps through four modes as the cycle count grows
            cyc++;
            if (stall_left > 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                case ((cyc / 200) % 4)
                    0: rsp_ch.ready <= 1'b1;
                    1: rsp_ch.ready <= 1'($urandom_range(0, 1));
                    2: begin
                        if ($urandom_range(0, 15) == 0) begin
                            stall_left = $urandom_range(1, 30);
                            rsp_ch.ready <= 1'b0;
                        end else begin
                            rsp_ch.ready <= 1'b1;
                        end
                    end
                    default: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // watchdog on cycles without any accepted transaction
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("sorted_record_table_top test failed");
            $finish;
        end
    end

    // reset, test sequence and verdict
    initial begin
        req_ch.valid    = 1'b0;
        req_ch.req_type = srt_pkg::REQ_INSERT;
        req_ch.key      = '0;
        req_ch.salary   = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_extremes_and_duplicates();
        test_fill_to_full();
        wait_for_results();
        test_random_churn();

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("sorted_record_table_top test passed");
        end else begin
            $display("sorted_record_table_top test failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/srt_pkg.sv
rtl/srt_req_if.sv
rtl/srt_rsp_if.sv
rtl/srt_cell.sv
rtl/srt_ctrl.sv
rtl/sorted_record_table_top.sv
tb/sv/tb_sorted_record_table_top.sv
